// ===== rtl/rbsi_pkg.sv =====
`default_nettype none
package rbsi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_AXES      = 3;
  localparam int QUO_W         = 32;
  // divider: one entry stage plus one stage per quotient bit
  localparam int DIV_LAT       = QUO_W + 1;
  // lane: entry register, divider, interval register
  localparam int LANE_LAT      = DIV_LAT + 2;
  // merge: interval merge, multiply, add and saturate
  localparam int MERGE_LAT     = 3;
  localparam int TOTAL_LAT     = LANE_LAT + MERGE_LAT;
  localparam int CFG_W         = 17;
  localparam logic [CFG_W-1:0] MIN_DEPTH_RST = 17'd7;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] box_center_x;
    logic signed [31:0] box_center_y;
    logic signed [31:0] box_center_z;
    logic [30:0]        box_half_x;
    logic [30:0]        box_half_y;
    logic [30:0]        box_half_z;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        hit_depth;
    logic signed [31:0] hit_pos_x;
    logic signed [31:0] hit_pos_y;
    logic signed [31:0] hit_pos_z;
  } out_item_t;

  // per-axis slab interval handed from a lane to the merge stage
  typedef struct packed {
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic               no_limit;
    logic               zmiss;
    logic signed [31:0] origin;
    logic signed [31:0] dir;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/rbsi_div.sv =====
`default_nettype none
module rbsi_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32,
  parameter int Q_W   = 32
) (
  input  wire logic             clk,
  input  wire logic             ce,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo
);
  logic [DEN_W-1:0] rem_r   [0:Q_W-1];
  logic [DEN_W-1:0] rem_nxt [1:Q_W-1];
  logic [DEN_W-1:0] den_r   [0:Q_W-1];
  logic [Q_W-1:0]   low_r   [0:Q_W-1];
  logic [Q_W-1:0]   q_r     [1:Q_W];
  logic [Q_W-1:0]   q_nxt   [1:Q_W];
  logic             ovf_r   [0:Q_W];
  logic [DEN_W-1:0] hi_ext;
  logic [DEN_W:0]   trial   [1:Q_W];
  logic             ge      [1:Q_W];

  assign hi_ext = DEN_W'(num[NUM_W-1:Q_W]);

  // one restoring step per stage
  always_comb begin
    for (int k = 1; k <= Q_W; k++) begin
      trial[k] = {rem_r[k-1], low_r[k-1][Q_W-k]};
      ge[k]    = trial[k] >= {1'b0, den_r[k-1]};
      if (k == 1) begin
        q_nxt[k] = {{(Q_W-1){1'b0}}, ge[k]};
      end else begin
        q_nxt[k] = {q_r[k-1][Q_W-2:0], ge[k]};
      end
      if (k < Q_W) begin
        rem_nxt[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_r[k-1]})
                           : trial[k][DEN_W-1:0];
      end
    end
  end

  // advance the pipeline
  always_ff @(posedge clk) begin
    if (ce) begin
      ovf_r[0] <= hi_ext >= den;
      rem_r[0] <= (hi_ext >= den) ? '0 : hi_ext;
      den_r[0] <= den;
      low_r[0] <= num[Q_W-1:0];
      for (int k = 1; k <= Q_W; k++) begin
        q_r[k]   <= q_nxt[k];
        ovf_r[k] <= ovf_r[k-1];
        if (k < Q_W) begin
          rem_r[k] <= rem_nxt[k];
          den_r[k] <= den_r[k-1];
          low_r[k] <= low_r[k-1];
        end
      end
    end
  end

  assign quo = ovf_r[Q_W] ? '1 : q_r[Q_W];
endmodule
`default_nettype wire

// ===== rtl/rbsi_lane.sv =====
`default_nettype none
module rbsi_lane #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               ce,
  input  wire logic signed [31:0] origin,
  input  wire logic signed [31:0] dir,
  input  wire logic signed [31:0] center,
  input  wire logic [30:0]        half,
  output rbsi_pkg::lane_res_t     res
);
  import rbsi_pkg::*;

  localparam int NUM_W = 33 + FRAC_BITS;
  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  logic signed [32:0] diff;
  logic [32:0]        mag_diff;
  logic [31:0]        mag_d;

  logic [NUM_W-1:0]   num_tc_r, num_w_r;
  logic [31:0]        den_r;
  logic               tc_neg_r [0:DIV_LAT];
  logic               zero_r   [0:DIV_LAT];
  logic               zmiss_r  [0:DIV_LAT];
  logic signed [31:0] org_r    [0:DIV_LAT];
  logic signed [31:0] dir_r    [0:DIV_LAT];

  logic [QUO_W-1:0]   q_tc, q_w;
  logic signed [33:0] tc_raw, tc_sat, w_sat;
  lane_res_t          res_r;

  // entry: magnitudes and numerators
  assign diff     = $signed({center[31], center}) - $signed({origin[31], origin});
  assign mag_diff = diff[32] ? 33'(-diff) : 33'(diff);
  assign mag_d    = dir[31] ? 32'(-dir) : 32'(dir);

  always_ff @(posedge clk) begin
    if (ce) begin
      num_tc_r    <= {mag_diff, {FRAC_BITS{1'b0}}};
      num_w_r     <= {2'b00, half, {FRAC_BITS{1'b0}}};
      den_r       <= (dir == '0) ? 32'd1 : mag_d;
      tc_neg_r[0] <= diff[32] ^ dir[31];
      zero_r[0]   <= dir == '0;
      zmiss_r[0]  <= (dir == '0) && (mag_diff > {2'b00, half});
      org_r[0]    <= origin;
      dir_r[0]    <= dir;
      for (int k = 1; k <= DIV_LAT; k++) begin
        tc_neg_r[k] <= tc_neg_r[k-1];
        zero_r[k]   <= zero_r[k-1];
        zmiss_r[k]  <= zmiss_r[k-1];
        org_r[k]    <= org_r[k-1];
        dir_r[k]    <= dir_r[k-1];
      end
    end
  end

  rbsi_div #(.NUM_W(NUM_W), .DEN_W(32), .Q_W(QUO_W)) u_div_tc (
    .clk(clk), .ce(ce), .num(num_tc_r), .den(den_r), .quo(q_tc)
  );

  rbsi_div #(.NUM_W(NUM_W), .DEN_W(32), .Q_W(QUO_W)) u_div_w (
    .clk(clk), .ce(ce), .num(num_w_r), .den(den_r), .quo(q_w)
  );

  // apply sign, saturate and form the slab interval
  always_comb begin
    tc_raw = tc_neg_r[DIV_LAT] ? -$signed({2'b00, q_tc}) : $signed({2'b00, q_tc});
    if (tc_raw > SAT_MAX) begin
      tc_sat = SAT_MAX;
    end else if (tc_raw < SAT_MIN) begin
      tc_sat = SAT_MIN;
    end else begin
      tc_sat = tc_raw;
    end
    w_sat = ($signed({2'b00, q_w}) > SAT_MAX) ? SAT_MAX : $signed({2'b00, q_w});
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r.lo       <= tc_sat - w_sat;
      res_r.hi       <= tc_sat + w_sat;
      res_r.no_limit <= zero_r[DIV_LAT];
      res_r.zmiss    <= zmiss_r[DIV_LAT];
      res_r.origin   <= org_r[DIV_LAT];
      res_r.dir      <= dir_r[DIV_LAT];
    end
  end

  assign res = res_r;
endmodule
`default_nettype wire

// ===== rtl/rbsi_merge.sv =====
`default_nettype none
module rbsi_merge #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          ce,
  input  wire logic [rbsi_pkg::CFG_W-1:0]    min_depth,
  input  wire rbsi_pkg::lane_res_t           lanes [rbsi_pkg::NUM_AXES],
  output rbsi_pkg::out_item_t                result
);
  import rbsi_pkg::*;

  localparam logic signed [34:0] NEG_INF = -35'sd17179869184;
  localparam logic signed [34:0] POS_INF = 35'sd17179869183;
  localparam logic signed [34:0] DEPTH_MAX = 35'sd2147483647;
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  logic signed [34:0] t_near, t_far;
  logic               any_miss, hit_c;

  logic               hit1_r, hit2_r;
  logic [30:0]        depth1_r, depth2_r;
  logic signed [31:0] org1_r [NUM_AXES];
  logic signed [31:0] dir1_r [NUM_AXES];
  logic signed [31:0] org2_r [NUM_AXES];
  logic signed [63:0] prod_r [NUM_AXES];
  logic signed [63:0] sum_c  [NUM_AXES];
  logic signed [31:0] pos_c  [NUM_AXES];
  out_item_t          result_r;

  // intersect the three slab intervals
  always_comb begin
    t_near   = NEG_INF;
    t_far    = POS_INF;
    any_miss = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      any_miss = any_miss | lanes[a].zmiss;
      if (!lanes[a].no_limit) begin
        if (35'(lanes[a].lo) > t_near) t_near = 35'(lanes[a].lo);
        if (35'(lanes[a].hi) < t_far)  t_far  = 35'(lanes[a].hi);
      end
    end
    hit_c = !any_miss && (t_near < t_far) && (t_near >= $signed({18'd0, min_depth}));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hit1_r   <= hit_c;
      depth1_r <= (t_near > DEPTH_MAX) ? 31'h7fffffff : t_near[30:0];
      for (int a = 0; a < NUM_AXES; a++) begin
        org1_r[a] <= lanes[a].origin;
        dir1_r[a] <= lanes[a].dir;
      end
    end
  end

  // scale direction by depth
  always_ff @(posedge clk) begin
    if (ce) begin
      hit2_r   <= hit1_r;
      depth2_r <= depth1_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        org2_r[a] <= org1_r[a];
        prod_r[a] <= 64'($signed(dir1_r[a]) * $signed({1'b0, depth1_r}));
      end
    end
  end

  // floor shift, add origin, saturate
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_c[a] = 64'($signed(org2_r[a])) + (prod_r[a] >>> FRAC_BITS);
      if (sum_c[a] > SAT_MAX) begin
        pos_c[a] = SAT_MAX[31:0];
      end else if (sum_c[a] < SAT_MIN) begin
        pos_c[a] = SAT_MIN[31:0];
      end else begin
        pos_c[a] = sum_c[a][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      result_r.hit       <= hit2_r;
      result_r.hit_depth <= hit2_r ? depth2_r : '0;
      result_r.hit_pos_x <= hit2_r ? pos_c[0] : '0;
      result_r.hit_pos_y <= hit2_r ? pos_c[1] : '0;
      result_r.hit_pos_z <= hit2_r ? pos_c[2] : '0;
    end
  end

  assign result = result_r;
endmodule
`default_nettype wire

// ===== rtl/ray_box_slab_intersection_unit.sv =====
`default_nettype none
// Ray versus axis-aligned box slab test in signed fixed point. One ray and
// box enter per cycle and one result leaves per cycle; each item passes 38
// register stages (entry, 33 stages of the per-axis pipelined dividers,
// interval, merge, multiply and saturate) before out_valid rises. Three axis
// lanes run in parallel and a merge stage intersects their intervals. The
// whole pipeline holds while a result waits on out_ready. The user must
// write min_depth through the cfg channel only while idle; the block
// itself does not enforce this.
module ray_box_slab_intersection_unit #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire rbsi_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rbsi_pkg::out_item_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [rbsi_pkg::CFG_W-1:0] cfg_data
);
  import rbsi_pkg::*;

  logic                 ce;
  logic [TOTAL_LAT-1:0] vld_r;
  logic [CFG_W-1:0]     min_depth_r;
  logic signed [31:0]   org   [NUM_AXES];
  logic signed [31:0]   dir   [NUM_AXES];
  logic signed [31:0]   ctr   [NUM_AXES];
  logic [30:0]          half  [NUM_AXES];
  lane_res_t            lanes [NUM_AXES];

  // advance whenever the output slot is free or being taken
  assign ce        = !vld_r[TOTAL_LAT-1] || out_ready;
  assign in_ready  = ce;
  assign out_valid = vld_r[TOTAL_LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r <= MIN_DEPTH_RST;
    end else if (cfg_valid) begin
      min_depth_r <= cfg_data;
    end
  end

  assign org[0]  = in_data.origin_x;
  assign org[1]  = in_data.origin_y;
  assign org[2]  = in_data.origin_z;
  assign dir[0]  = in_data.dir_x;
  assign dir[1]  = in_data.dir_y;
  assign dir[2]  = in_data.dir_z;
  assign ctr[0]  = in_data.box_center_x;
  assign ctr[1]  = in_data.box_center_y;
  assign ctr[2]  = in_data.box_center_z;
  assign half[0] = in_data.box_half_x;
  assign half[1] = in_data.box_half_y;
  assign half[2] = in_data.box_half_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .ce(ce), .origin(org[a]), .dir(dir[a]),
      .center(ctr[a]), .half(half[a]), .res(lanes[a])
    );
  end

  rbsi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .ce(ce), .min_depth(min_depth_r), .lanes(lanes), .result(out_data)
  );
endmodule
`default_nettype wire
